FILE: rtl/crcpr_pkg.sv
// ----------------------------------------------------------------------------
// crcpr_pkg
// Shared types, constants and the CRC-8 step for the framed packet receiver.
// ----------------------------------------------------------------------------
package crcpr_pkg;

   localparam int BYTE_W       = 8;
   localparam int DATA_BYTES   = 16;
   localparam int IDX_W        = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
   localparam int SLOT_W       = 1;
   localparam int RAM_ADDR_W   = SLOT_W + IDX_W;
   localparam int RAM_DEPTH    = 1 << RAM_ADDR_W;
   localparam int DESC_DEPTH   = 2;
   localparam int CSR_IDX_W    = 1;

   localparam logic [BYTE_W-1:0] CRC_POLY      = 8'h07;
   localparam logic [BYTE_W-1:0] BYTE_ALL_ONES = 8'hff;
   localparam logic [IDX_W-1:0]  LAST_IDX      = IDX_W'(DATA_BYTES - 1);

   typedef enum logic [1:0] {
      VD_CRC_BAD  = 2'd0,
      VD_RESEND   = 2'd1,
      VD_ACK_SEEN = 2'd2,
      VD_ACCEPT   = 2'd3
   } verdict_type;

   typedef enum logic [1:0] {
      PH_LENGTH = 2'd0,
      PH_DATA   = 2'd1,
      PH_CRC    = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      BK_IDLE = 2'd0,
      BK_LEN  = 2'd1,
      BK_DATA = 2'd2
   } back_state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RETX_CODE = 1'b0,
      CSR_ACK_CODE  = 1'b1
   } csr_index_type;

   // One packet verdict handed from the front to the back
   typedef struct packed {
      verdict_type         verdict;
      logic [SLOT_W-1:0]   slot;
      logic [BYTE_W-1:0]   length;
   } desc_type;

   // MSB-first CRC-8 over one byte, no final xor
   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/crcpr_ram.sv
// ----------------------------------------------------------------------------
// crcpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crcpr_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/crcpr_desc_fifo.sv
// ----------------------------------------------------------------------------
// crcpr_desc_fifo
// Short queue of packet verdicts between the front and the back.
// ----------------------------------------------------------------------------
module crcpr_desc_fifo
   import crcpr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   output logic     full,
   input  logic     pop,
   output desc_type head_desc,
   output logic     empty
);

   localparam int PTR_W = $clog2(DESC_DEPTH);
   localparam int CNT_W = $clog2(DESC_DEPTH + 1);

   desc_type          entry_ff [DESC_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DESC_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_desc = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DESC_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DESC_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

FILE: rtl/crcpr_front.sv
// ----------------------------------------------------------------------------
// crcpr_front
// Frame tracking, CRC accumulation, data capture and verdict classification.
// ----------------------------------------------------------------------------
module crcpr_front
   import crcpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [BYTE_W-1:0]     csr_data,
   input  logic                  push,
   input  logic [BYTE_W-1:0]     rx_byte,
   output logic                  full,
   output logic                  ram_wr_en,
   output logic [RAM_ADDR_W-1:0] ram_wr_addr,
   output logic [BYTE_W-1:0]     ram_wr_data,
   output logic                  desc_push,
   output desc_type              desc_out,
   input  logic                  desc_full,
   input  logic                  slot_release
);

   phase_type          phase_ff, phase_in;
   logic [IDX_W-1:0]   count_ff, count_in;
   logic [BYTE_W-1:0]  crc_ff, crc_in;
   logic [BYTE_W-1:0]  length_ff, length_in;
   logic [BYTE_W-1:0]  first_ff, first_in;
   logic               rest_ones_ff, rest_ones_in;
   logic [SLOT_W-1:0]  wr_slot_ff, wr_slot_in;
   logic [1:0]         slots_used_ff, slots_used_in;
   logic [BYTE_W-1:0]  retx_code_ff, ack_code_ff;
   logic               take;
   logic               single_byte;
   verdict_type        verdict;

   // Stall data bytes while both buffer slots are in use, and the CRC byte
   // while the verdict queue is full
   always_comb begin
      case (phase_ff)
         PH_DATA: full = (slots_used_ff == 2'd2);
         PH_CRC:  full = desc_full;
         default: full = 1'b0;
      endcase
   end

   assign take        = push && !full;
   assign single_byte = (length_ff == 8'd1) && rest_ones_ff;

   always_comb begin
      if (rx_byte != crc_ff) begin
         verdict = VD_CRC_BAD;
      end else if (single_byte && first_ff == retx_code_ff) begin
         verdict = VD_RESEND;
      end else if (single_byte && first_ff == ack_code_ff) begin
         verdict = VD_ACK_SEEN;
      end else begin
         verdict = VD_ACCEPT;
      end
   end

   assign ram_wr_en   = take && (phase_ff == PH_DATA);
   assign ram_wr_addr = {wr_slot_ff, count_ff};
   assign ram_wr_data = rx_byte;

   assign desc_push        = take && (phase_ff == PH_CRC);
   assign desc_out.verdict = verdict;
   assign desc_out.slot    = wr_slot_ff;
   assign desc_out.length  = length_ff;

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      length_in    = length_ff;
      first_in     = first_ff;
      rest_ones_in = rest_ones_ff;
      wr_slot_in   = wr_slot_ff;
      if (take) begin
         case (phase_ff)
            PH_DATA: begin
               crc_in = crc8_update(crc_ff, rx_byte);
               if (count_ff == '0) begin
                  first_in = rx_byte;
               end else begin
                  rest_ones_in = rest_ones_ff && (rx_byte == BYTE_ALL_ONES);
               end
               if (count_ff == LAST_IDX) begin
                  count_in = '0;
                  phase_in = PH_CRC;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            PH_CRC: begin
               phase_in = PH_LENGTH;
               count_in = '0;
               if (verdict == VD_ACCEPT) begin
                  wr_slot_in = wr_slot_ff + 1'b1;
               end
            end
            default: begin
               length_in    = rx_byte;
               crc_in       = crc8_update('0, rx_byte);
               count_in     = '0;
               rest_ones_in = 1'b1;
               phase_in     = PH_DATA;
            end
         endcase
      end
   end

   always_comb begin
      slots_used_in = slots_used_ff;
      if ((desc_push && verdict == VD_ACCEPT) && !slot_release) begin
         slots_used_in = slots_used_ff + 1'b1;
      end else if (!(desc_push && verdict == VD_ACCEPT) && slot_release) begin
         slots_used_in = slots_used_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LENGTH;
         count_ff      <= '0;
         crc_ff        <= '0;
         length_ff     <= '0;
         first_ff      <= '0;
         rest_ones_ff  <= 1'b1;
         wr_slot_ff    <= '0;
         slots_used_ff <= '0;
         retx_code_ff  <= '0;
         ack_code_ff   <= '0;
      end else begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         crc_ff        <= crc_in;
         length_ff     <= length_in;
         first_ff      <= first_in;
         rest_ones_ff  <= rest_ones_in;
         wr_slot_ff    <= wr_slot_in;
         slots_used_ff <= slots_used_in;
         if (csr_valid && csr_index == CSR_RETX_CODE) begin
            retx_code_ff <= csr_data;
         end
         if (csr_valid && csr_index == CSR_ACK_CODE) begin
            ack_code_ff <= csr_data;
         end
      end
   end

endmodule

FILE: rtl/crcpr_back.sv
// ----------------------------------------------------------------------------
// crcpr_back
// Turns queued verdicts into results and streams accepted packets from RAM.
// ----------------------------------------------------------------------------
module crcpr_back
   import crcpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  desc_type              head_desc,
   input  logic                  desc_empty,
   output logic                  desc_pop,
   output logic                  ram_rd_en,
   output logic [RAM_ADDR_W-1:0] ram_rd_addr,
   input  logic [BYTE_W-1:0]     ram_rd_data,
   output logic                  slot_release,
   input  logic                  pop,
   output logic                  empty,
   output logic                  is_payload,
   output logic [1:0]            verdict,
   output logic [BYTE_W-1:0]     payload_byte,
   output logic                  last
);

   back_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   count_ff, count_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [BYTE_W-1:0]  length_ff, length_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_isp_ff, out_isp_in;
   logic [1:0]         out_vd_ff, out_vd_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic               out_last_ff, out_last_in;
   logic               advance;
   logic               emit;

   // The output register takes a new result when it is empty or being popped
   assign advance = !out_valid_ff || pop;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (advance && !desc_empty && head_desc.verdict == VD_ACCEPT) begin
               state_in = BK_LEN;
            end
         end
         BK_LEN: begin
            if (advance) begin
               state_in = BK_DATA;
            end
         end
         BK_DATA: begin
            if (advance && count_ff == LAST_IDX) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      emit         = 1'b0;
      desc_pop     = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = {slot_ff, count_ff};
      slot_release = 1'b0;
      out_isp_in   = out_isp_ff;
      out_vd_in    = out_vd_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      length_in    = length_ff;
      case (state_ff)
         BK_IDLE: begin
            if (advance && !desc_empty) begin
               emit        = 1'b1;
               desc_pop    = 1'b1;
               out_isp_in  = 1'b0;
               out_vd_in   = head_desc.verdict;
               out_byte_in = '0;
               out_last_in = (head_desc.verdict != VD_ACCEPT);
               slot_in     = head_desc.slot;
               length_in   = head_desc.length;
            end
         end
         BK_LEN: begin
            if (advance) begin
               emit        = 1'b1;
               out_isp_in  = 1'b1;
               out_vd_in   = VD_ACCEPT;
               out_byte_in = length_ff;
               out_last_in = 1'b0;
               ram_rd_en   = 1'b1;
               ram_rd_addr = {slot_ff, IDX_W'(0)};
               count_in    = '0;
            end
         end
         BK_DATA: begin
            if (advance) begin
               emit        = 1'b1;
               out_isp_in  = 1'b1;
               out_vd_in   = VD_ACCEPT;
               out_byte_in = ram_rd_data;
               out_last_in = (count_ff == LAST_IDX);
               if (count_ff == LAST_IDX) begin
                  slot_release = 1'b1;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = {slot_ff, IDX_W'(count_ff + 1'b1)};
                  count_in    = count_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      length_ff   <= length_in;
      out_isp_ff  <= out_isp_in;
      out_vd_ff   <= out_vd_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign empty        = !out_valid_ff;
   assign is_payload   = out_isp_ff;
   assign verdict      = out_vd_ff;
   assign payload_byte = out_byte_ff;
   assign last         = out_last_ff;

endmodule

FILE: rtl/crc8_framed_packet_receiver.sv
// A CRC byte's verdict is written to the verdict queue, then to the output register, before it is shown.
// Throughput: one received byte per cycle while full is low; results leave at one per cycle while pop is high.
// An accepted packet streams 18 results back to back from a two-slot buffer RAM;
// data bytes stall while both slots hold packets not yet streamed, CRC bytes
// while the two-entry verdict queue is full.
// Reset: synchronous, active high; clears framing, CRC, queue, output and codes.
// ----------------------------------------------------------------------------
// crc8_framed_packet_receiver
// Framed byte receiver with CRC-8 check and acknowledge/retransmit verdicts.
// ----------------------------------------------------------------------------
module crc8_framed_packet_receiver
   import crcpr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Received byte channel
   input  logic                 push,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   output logic                 full,
   // Result channel
   output logic                 empty,
   input  logic                 pop,
   output logic                 rsp_is_payload,
   output logic [1:0]           rsp_verdict,
   output logic [BYTE_W-1:0]    rsp_payload_byte,
   output logic                 rsp_last,
   // Configuration write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data
);

   logic                  ram_wr_en;
   logic [RAM_ADDR_W-1:0] ram_wr_addr;
   logic [BYTE_W-1:0]     ram_wr_data;
   logic                  ram_rd_en;
   logic [RAM_ADDR_W-1:0] ram_rd_addr;
   logic [BYTE_W-1:0]     ram_rd_data;
   logic                  desc_push;
   desc_type              desc_in_q;
   logic                  desc_full;
   logic                  desc_pop;
   desc_type              desc_head;
   logic                  desc_empty;
   logic                  slot_release;

   // Code writes are registered directly, so the channel never back-pressures
   assign csr_ready = 1'b1;

   // Front: frame the byte stream, run the CRC, fill a buffer slot and
   // classify the packet on its CRC byte
   crcpr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .push         (push),
      .rx_byte      (req_rx_byte),
      .full         (full),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .desc_push    (desc_push),
      .desc_out     (desc_in_q),
      .desc_full    (desc_full),
      .slot_release (slot_release)
   );

   // Verdict queue decouples classification from streaming
   crcpr_desc_fifo u_desc_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_desc (desc_in_q),
      .full      (desc_full),
      .pop       (desc_pop),
      .head_desc (desc_head),
      .empty     (desc_empty)
   );

   // Two packet slots of data bytes, indexed by {slot, byte index}
   crcpr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RAM_DEPTH)
   ) u_buf_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Back: emit the verdict, then the length and data bytes of accepted
   // packets, and hand the slot back once the last byte leaves
   crcpr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_desc    (desc_head),
      .desc_empty   (desc_empty),
      .desc_pop     (desc_pop),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .slot_release (slot_release),
      .pop          (pop),
      .empty        (empty),
      .is_payload   (rsp_is_payload),
      .verdict      (rsp_verdict),
      .payload_byte (rsp_payload_byte),
      .last         (rsp_last)
   );

endmodule

FILE: rtl/crcpr_checker.sv
// ----------------------------------------------------------------------------
// crcpr_checker
// Port-level checks on the result stream of the packet receiver.
// ----------------------------------------------------------------------------
module crcpr_checker
   import crcpr_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              empty,
   input logic              pop,
   input logic              rsp_is_payload,
   input logic [1:0]        rsp_verdict,
   input logic [BYTE_W-1:0] rsp_payload_byte,
   input logic              rsp_last
);

   // Nothing is shown right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> empty)
      else $error("result shown right after reset");

   // Streamed bytes belong only to accepted packets
   a_payload_accepted: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_is_payload) |-> (rsp_verdict == VD_ACCEPT))
      else $error("payload byte without accept verdict");

   // A verdict other than accept is the only result of its byte
   a_verdict_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_is_payload && rsp_verdict != VD_ACCEPT) |-> rsp_last)
      else $error("reject verdict not marked last");

   // An accept verdict is followed by the packet bytes
   a_accept_then_payload: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_is_payload && rsp_verdict == VD_ACCEPT)
      |=> (empty || rsp_is_payload))
      else $error("accept verdict not followed by payload");

   // A stalled result holds
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_payload_byte) && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind crc8_framed_packet_receiver crcpr_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .empty            (empty),
   .pop              (pop),
   .rsp_is_payload   (rsp_is_payload),
   .rsp_verdict      (rsp_verdict),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_last         (rsp_last)
);

FILE: tb/crc8_framed_packet_receiver_tb.sv
// ----------------------------------------------------------------------------
// crc8_framed_packet_receiver_tb
// Drives framed packets (length, data, CRC-8) into the receiver and checks
// every verdict and streamed byte against a cycle-free predictor of the
// framing, CRC and acknowledge/retransmit decisions kept in this bench.
// ----------------------------------------------------------------------------
module crc8_framed_packet_receiver_tb;
   import crcpr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 12;

   // One result as seen on the rsp_ ports
   typedef struct packed {
      logic              is_payload;
      verdict_type       verdict;
      logic [BYTE_W-1:0] payload_byte;
      logic              last;
   } rx_result_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 push;
   logic [BYTE_W-1:0]    req_rx_byte;
   logic                 full;
   logic                 empty;
   logic                 pop;
   logic                 rsp_is_payload;
   logic [1:0]           rsp_verdict;
   logic [BYTE_W-1:0]    rsp_payload_byte;
   logic                 rsp_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_data;

   // Predictor state: framing, CRC and the current packet's bytes
   phase_type         frame_phase;
   int                data_count;
   logic [BYTE_W-1:0] running_crc;
   logic [BYTE_W-1:0] length_byte;
   logic [BYTE_W-1:0] packet_bytes [DATA_BYTES];
   logic [BYTE_W-1:0] retx_code;
   logic [BYTE_W-1:0] ack_code;

   // Results still owed by the receiver, oldest first
   rx_result_type pending_results [$];

   // Packet under construction for send_packet
   logic [BYTE_W-1:0] pkt_len;
   logic [BYTE_W-1:0] pkt_data [DATA_BYTES];

   bit gaps_on = 1'b1;     // random idle bursts on both sides
   int long_hold = 0;      // cycles the result side must hold off pop
   int mismatches = 0;
   int cycle_count = 0;

   crc8_framed_packet_receiver DUT (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .req_rx_byte      (req_rx_byte),
      .full             (full),
      .empty            (empty),
      .pop              (pop),
      .rsp_is_payload   (rsp_is_payload),
      .rsp_verdict      (rsp_verdict),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // Backstop: end the run if handshakes stop making progress
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // MSB-first CRC-8, polynomial 0x07, one byte at a time
   function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] acc;
      acc = crc ^ b;
      repeat (BYTE_W) acc = acc[BYTE_W-1] ? ((acc << 1) ^ 8'h07) : (acc << 1);
      return acc;
   endfunction

   function automatic void queue_result(input logic isp, input verdict_type vd,
                                        input logic [BYTE_W-1:0] pb, input logic lst);
      rx_result_type r;
      r.is_payload   = isp;
      r.verdict      = vd;
      r.payload_byte = pb;
      r.last         = lst;
      pending_results.push_back(r);
   endfunction

   // True when the held packet is a single-byte packet carrying code
   function automatic bit holds_single_code(input logic [BYTE_W-1:0] code);
      bit hit;
      hit = (length_byte == 8'd1) && (packet_bytes[0] == code);
      for (int i = 1; i < DATA_BYTES; i++) begin
         if (packet_bytes[i] != 8'hff) hit = 1'b0;
      end
      return hit;
   endfunction

   // Advance the framing by one received byte and queue what it causes
   function automatic void frame_byte_results(input logic [BYTE_W-1:0] b);
      if (frame_phase == PH_DATA) begin
         packet_bytes[data_count] = b;
         running_crc = crc8_next(running_crc, b);
         data_count++;
         if (data_count >= DATA_BYTES) begin
            data_count  = 0;
            frame_phase = PH_CRC;
         end
      end else if (frame_phase != PH_CRC) begin
         length_byte = b;
         running_crc = crc8_next(8'h00, b);
         data_count  = 0;
         frame_phase = PH_DATA;
      end else begin
         frame_phase = PH_LENGTH;
         data_count  = 0;
         // retransmit wins when both codes match the same packet
         if (b != running_crc) begin
            queue_result(1'b0, VD_CRC_BAD, 8'h00, 1'b1);
         end else if (holds_single_code(retx_code)) begin
            queue_result(1'b0, VD_RESEND, 8'h00, 1'b1);
         end else if (holds_single_code(ack_code)) begin
            queue_result(1'b0, VD_ACK_SEEN, 8'h00, 1'b1);
         end else begin
            queue_result(1'b0, VD_ACCEPT, 8'h00, 1'b0);
            queue_result(1'b1, VD_ACCEPT, length_byte, 1'b0);
            for (int i = 0; i < DATA_BYTES; i++) begin
               queue_result(1'b1, VD_ACCEPT, packet_bytes[i], i == DATA_BYTES - 1);
            end
         end
      end
   endfunction

   // ------------------------------------------------------------------------
   // Result side: pop driver and checker
   // ------------------------------------------------------------------------

   // Drive pop; honor a requested long hold-off, else stall in random bursts
   initial begin
      pop <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (long_hold > 0) begin
            pop <= 1'b0;
            repeat (long_hold) @(posedge clock);
            long_hold = 0;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Compare every accepted result with the oldest one owed
   always @(posedge clock) begin : check_results
      rx_result_type want;
      if (reset === 1'b0 && pop && !empty) begin
         if (pending_results.size() == 0) begin
            $error("result with nothing owed: is_payload %0b verdict %0d byte %0h last %0b",
                   rsp_is_payload, rsp_verdict, rsp_payload_byte, rsp_last);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_is_payload !== want.is_payload) begin
               $error("is_payload: expected %0b, got %0b", want.is_payload, rsp_is_payload);
               mismatches++;
            end
            if (rsp_verdict !== want.verdict) begin
               $error("verdict: expected %0d, got %0d", want.verdict, rsp_verdict);
               mismatches++;
            end
            if (rsp_payload_byte !== want.payload_byte) begin
               $error("payload_byte: expected %0h, got %0h",
                      want.payload_byte, rsp_payload_byte);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------

   // Offer one byte until the transfer happens, then maybe idle for a burst
   task automatic push_byte(input logic [BYTE_W-1:0] b);
      push        <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (full);
      frame_byte_results(b);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Drop push, wait for every owed result, then let the pipeline settle
   task automatic drain_results;
      if (push) push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one code register; only called with the receiver drained
   task automatic write_code(input csr_index_type idx, input logic [BYTE_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_RETX_CODE) retx_code = val;
      else ack_code = val;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_codes(input logic [BYTE_W-1:0] retx, input logic [BYTE_W-1:0] ack);
      drain_results();
      write_code(CSR_RETX_CODE, retx);
      write_code(CSR_ACK_CODE, ack);
   endtask

   // Send pkt_len, pkt_data and their CRC, xor'ing crc_flip into the CRC byte
   task automatic send_packet(input logic [BYTE_W-1:0] crc_flip);
      logic [BYTE_W-1:0] crc;
      crc = crc8_next(8'h00, pkt_len);
      for (int i = 0; i < DATA_BYTES; i++) crc = crc8_next(crc, pkt_data[i]);
      push_byte(pkt_len);
      for (int i = 0; i < DATA_BYTES; i++) push_byte(pkt_data[i]);
      push_byte(crc ^ crc_flip);
   endtask

   function automatic void fill_single(input logic [BYTE_W-1:0] code);
      pkt_len = 8'd1;
      pkt_data[0] = code;
      for (int i = 1; i < DATA_BYTES; i++) pkt_data[i] = 8'hff;
   endfunction

   function automatic void fill_random;
      pkt_len = BYTE_W'($urandom_range(0, 255));
      for (int i = 0; i < DATA_BYTES; i++) pkt_data[i] = BYTE_W'($urandom_range(0, 255));
   endfunction

   // Bias toward the bytes that sit on the edges of the field
   function automatic void fill_extremes;
      logic [BYTE_W-1:0] picks [4] = '{8'h00, 8'hff, 8'h80, 8'h01};
      pkt_len = picks[$urandom_range(0, 3)];
      for (int i = 0; i < DATA_BYTES; i++) begin
         pkt_data[i] = ($urandom_range(0, 4) == 4) ? BYTE_W'($urandom_range(0, 255))
                                                   : picks[$urandom_range(0, 3)];
      end
   endfunction

   // One packet of a random kind; mostly well formed, some near misses and noise
   task automatic send_random_packet;
      int kind;
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
         fill_random();
         send_packet(8'h00);
      end else if (kind == 4) begin
         fill_single(retx_code);
         send_packet(8'h00);
      end else if (kind == 5) begin
         fill_single(ack_code);
         send_packet(8'h00);
      end else if (kind == 6) begin
         // single-byte packet with one thing off: length, a filler byte or the code
         fill_single($urandom_range(0, 1) ? retx_code : ack_code);
         case ($urandom_range(0, 2))
            0: begin
               pkt_len ^= BYTE_W'($urandom_range(1, 255));
            end
            1: begin
               pkt_data[$urandom_range(1, DATA_BYTES - 1)] ^= BYTE_W'($urandom_range(1, 255));
            end
            default: begin
               pkt_data[0] ^= BYTE_W'($urandom_range(1, 255));
            end
         endcase
         send_packet(8'h00);
      end else if (kind == 7) begin
         // corrupt the CRC of an otherwise special packet
         fill_single($urandom_range(0, 1) ? retx_code : ack_code);
         send_packet(BYTE_W'($urandom_range(1, 255)));
      end else if (kind == 8) begin
         // noise: random bytes throughout, CRC usually wrong
         fill_random();
         send_packet(BYTE_W'($urandom_range(0, 255)));
      end else begin
         fill_extremes();
         send_packet(8'h00);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Resend, acknowledge and CRC-bad verdicts, equal codes after reset
   task automatic test_directed;
      // both codes reset to zero: the retransmit verdict must win
      fill_single(8'h00);
      send_packet(8'h00);
      set_codes(8'hff, 8'h00);
      fill_single(8'h00);
      send_packet(8'h00);
      // zero packet with its CRC top bit flipped
      pkt_len = 8'h00;
      for (int i = 0; i < DATA_BYTES; i++) pkt_data[i] = 8'h00;
      send_packet(8'h80);
   endtask

   // Random codes, then equal codes, one random packet under each
   task automatic test_random_traffic;
      logic [BYTE_W-1:0] shared;
      for (int phase = 0; phase < 2; phase++) begin
         shared = BYTE_W'($urandom_range(0, 255));
         if (phase == 1) set_codes(shared, shared);
         else set_codes(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
         send_random_packet();
      end
   endtask

   // Hold the result side off while packets keep arriving, so both buffer
   // slots fill and the input stalls; then pause until everything drains
   task automatic test_backpressure;
      gaps_on = 1'b0;
      long_hold = 300;
      repeat (3) begin
         fill_random();
         send_packet(8'h00);
      end
      drain_results();
      gaps_on = 1'b1;
   endtask

   // Opposite code extremes, back to back traffic with no idling anywhere:
   // an acknowledge, then the longest length byte with alternating data
   task automatic test_final_streaming;
      set_codes(8'h00, 8'hff);
      gaps_on = 1'b0;
      fill_single(8'hff);
      send_packet(8'h00);
      pkt_len = 8'hff;
      for (int i = 0; i < DATA_BYTES; i++) pkt_data[i] = i[0] ? 8'hff : 8'h00;
      send_packet(8'h00);
   endtask

   initial begin
      reset       <= 1'b1;
      push        <= 1'b0;
      req_rx_byte <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= CSR_RETX_CODE;
      csr_data    <= '0;
      frame_phase = PH_LENGTH;
      data_count  = 0;
      running_crc = '0;
      length_byte = '0;
      retx_code   = '0;
      ack_code    = '0;
      for (int i = 0; i < DATA_BYTES; i++) packet_bytes[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_traffic();
      test_backpressure();
      test_final_streaming();

      drain_results();
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
